[design/gta_pkg.sv]
// Shared types, constants and the tanh table for the GELU activation pipeline.
package gta_pkg;

  localparam int TANH_ENTRIES = 256;
  localparam int IDX_W        = $clog2(TANH_ENTRIES);

  localparam int X_W    = 16;
  localparam int AX_W   = 17;
  localparam int SQ_W   = 31;
  localparam int CUBE_W = 46;
  localparam int SM_W   = 57;
  localparam int HI_W   = SM_W - 32;
  localparam int K_W    = 16;
  localparam int C_W    = 12;
  localparam int PH_W   = HI_W + K_W;
  localparam int PL_W   = 32 + K_W;
  localparam int SUM_W  = 42;
  localparam int UM_W   = 17;
  localparam int FRAC_W = 14;
  localparam int P_W    = FRAC_W + IDX_W + 1;
  localparam int T_W    = 16;
  localparam int F_W    = 17;
  localparam int PROD_W = 32;

  localparam logic [K_W-1:0] GELU_K = 16'd52290;
  localparam logic [C_W-1:0] GELU_C = 12'd2930;
  localparam logic [T_W-1:0] T_ONE  = 16'd32768;

  typedef struct packed {
    logic            neg;
    logic            last;
    logic [AX_W-1:0] ax;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [SM_W-1:0] sm;
  } inner_t;

  typedef struct packed {
    meta_t             meta;
    logic              sat;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
  } pos_t;

  typedef struct packed {
    meta_t          meta;
    logic [F_W-1:0] f;
  } factor_t;

  typedef logic [T_W-1:0] tanh_tab_t [TANH_ENTRIES];

  // unsigned quotient by shift and subtract, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4*i/N) in Q1.15, via e^(-2t) = (e^(-i/N))^8 in Q31
  function automatic tanh_tab_t tanh_table();
    tanh_tab_t       tab;
    longint unsigned r;
    longint unsigned term;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint          sum;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      r    = (longint'(i) << 31) / TANH_ENTRIES;
      term = 64'd2147483648;
      sum  = 64'sd2147483648;
      for (int k = 1; k <= 24; k++) begin
        term = udiv64((term * r) >> 31, 64'(k));
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = longint'(sum);
      for (int s = 0; s < 3; s++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      if (e > 64'd2147483648) begin
        e = 64'd2147483648;
      end
      num    = (64'd2147483648 - e) << 16;
      den    = 64'd2147483648 + e;
      tab[i] = T_W'(udiv64(num + den, den << 1));
    end
    return tab;
  endfunction

endpackage

[design/gelu_tanh_activation.sv]
// GELU (tanh form) on a stream of signed Q4.12 samples, one transfer per cycle.
//
// Each input transfer carries one Q4.12 sample in tdata[15:0] and a tlast flag;
// each output transfer carries GELU(x) in Q4.12, rounded to nearest and
// saturated, with tlast copied from the same sample. The block is a 12-stage
// pipeline (cubic polynomial, scale and round of u, tanh table lookup with
// linear interpolation, final product and saturation) that takes a new sample
// every cycle, so throughput is one sample per clock while the output does not
// stall. A stall on the output holds every stage at once; s_axis_tready_o is
// low only while a result waits and the consumer is not ready. The tanh table
// is a constant ROM built at elaboration.
module gelu_tanh_activation (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [gta_pkg::X_W-1:0]  s_axis_tdata_i,   // [15:0] sample_in
  input  logic                     s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [gta_pkg::X_W-1:0]  m_axis_tdata_o,   // [15:0] sample_out
  output logic                     m_axis_tlast_o
);

  logic              en;
  logic              inner_vld, pos_vld, fac_vld;
  gta_pkg::inner_t   inner;
  gta_pkg::pos_t     pos;
  gta_pkg::factor_t  factor;

  // advance the whole pipe unless a finished result is waiting and the consumer is not ready
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  gta_cubic u_cubic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .sample_i (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .valid_o  (inner_vld),
    .inner_o  (inner)
  );

  gta_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (inner_vld),
    .inner_i (inner),
    .valid_o (pos_vld),
    .pos_o   (pos)
  );

  gta_tanh u_tanh (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pos_vld),
    .pos_i    (pos),
    .valid_o  (fac_vld),
    .factor_o (factor)
  );

  gta_output u_output (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (fac_vld),
    .factor_i (factor),
    .valid_o  (m_axis_tvalid_o),
    .sample_o (m_axis_tdata_o),
    .last_o   (m_axis_tlast_o)
  );

endmodule

[design/gta_cubic.sv]
// Inner polynomial stages: |x|, x^2, x^3, C*x^3 and |x|*2^40 + C*|x|^3.
module gta_cubic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [gta_pkg::X_W-1:0]      sample_i,
  input  logic                         last_i,
  output logic                         valid_o,
  output gta_pkg::inner_t              inner_o
);

  logic [3:0] vld_q;

  gta_pkg::meta_t              m1_d, m1_q, m2_q, m3_q;
  logic [gta_pkg::SQ_W-1:0]    sq_d, sq_q;
  logic [gta_pkg::CUBE_W-1:0]  cube_d, cube_q;
  logic [gta_pkg::SM_W-1:0]    cc_d, cc_q;
  gta_pkg::inner_t             inner_d, inner_q;

  always_comb begin
    m1_d.neg  = sample_i[gta_pkg::X_W-1];
    m1_d.last = last_i;
    m1_d.ax   = m1_d.neg ? gta_pkg::AX_W'(17'h10000 - {1'b0, sample_i})
                         : {1'b0, sample_i};
    sq_d      = gta_pkg::SQ_W'(m1_d.ax) * gta_pkg::SQ_W'(m1_d.ax);
    cube_d    = gta_pkg::CUBE_W'(gta_pkg::CUBE_W'(sq_q) * gta_pkg::CUBE_W'(m1_q.ax));
    cc_d      = gta_pkg::SM_W'(gta_pkg::SM_W'(cube_q) * gta_pkg::SM_W'(gta_pkg::GELU_C));
    inner_d.meta = m3_q;
    inner_d.sm   = (gta_pkg::SM_W'(m3_q.ax) << 40) + cc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1_d;
      sq_q    <= sq_d;
      m2_q    <= m1_q;
      cube_q  <= cube_d;
      m3_q    <= m2_q;
      cc_q    <= cc_d;
      inner_q <= inner_d;
    end
  end

  assign valid_o = vld_q[3];
  assign inner_o = inner_q;

endmodule

[design/gta_scale.sv]
// Scale by sqrt(2/pi), round u to Q4.12 and locate it on the tanh grid.
module gta_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  gta_pkg::inner_t inner_i,
  output logic            valid_o,
  output gta_pkg::pos_t   pos_o
);

  logic [2:0] vld_q;

  gta_pkg::meta_t              m5_q, m6_q;
  logic [gta_pkg::PH_W-1:0]    ph_d, ph_q;
  logic [gta_pkg::PL_W-1:0]    pl_d, pl_q;
  logic [gta_pkg::SUM_W-1:0]   sum;
  logic [gta_pkg::UM_W-1:0]    um;
  logic                        sat_d, sat_q;
  logic [gta_pkg::FRAC_W-1:0]  um_d, um_q;
  logic [gta_pkg::P_W-1:0]     p;
  gta_pkg::pos_t               pos_d, pos_q;

  always_comb begin
    ph_d  = gta_pkg::PH_W'(inner_i.sm[gta_pkg::SM_W-1:32]) * gta_pkg::PH_W'(gta_pkg::GELU_K);
    pl_d  = gta_pkg::PL_W'(inner_i.sm[31:0]) * gta_pkg::PL_W'(gta_pkg::GELU_K);
    // round to nearest at bit 56 of the full product
    sum   = gta_pkg::SUM_W'(ph_q) + (gta_pkg::SUM_W'(1) << 23)
          + gta_pkg::SUM_W'(pl_q[gta_pkg::PL_W-1:32]);
    um    = sum[24 +: gta_pkg::UM_W];
    sat_d = |um[gta_pkg::UM_W-1:gta_pkg::FRAC_W];
    um_d  = um[gta_pkg::FRAC_W-1:0];
    p     = gta_pkg::P_W'(um_q) * gta_pkg::P_W'(gta_pkg::TANH_ENTRIES);
    pos_d.meta = m6_q;
    pos_d.sat  = sat_q;
    pos_d.idx  = p[gta_pkg::FRAC_W +: gta_pkg::IDX_W];
    pos_d.frac = p[gta_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m5_q  <= inner_i.meta;
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      m6_q  <= m5_q;
      sat_q <= sat_d;
      um_q  <= um_d;
      pos_q <= pos_d;
    end
  end

  assign valid_o = vld_q[2];
  assign pos_o   = pos_q;

  a_idx_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !pos_q.sat |-> 32'(pos_q.idx) < gta_pkg::TANH_ENTRIES)
    else $error("tanh grid index beyond table");

endmodule

[design/gta_tanh.sv]
// Table lookup, linear interpolation and the factor 1 + tanh(u) in Q2.15.
module gta_tanh (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gta_pkg::pos_t     pos_i,
  output logic              valid_o,
  output gta_pkg::factor_t  factor_o
);

  localparam gta_pkg::tanh_tab_t TanhTab = gta_pkg::tanh_table();

  logic [2:0] vld_q;

  gta_pkg::meta_t               m8_q, m9_q;
  logic                         sat8_q, sat9_q;
  logic [gta_pkg::IDX_W:0]      idx_n;
  logic [gta_pkg::T_W-1:0]      lo_d, hi_d, lo8_q, lo9_q, diff_d, diff_q;
  logic [gta_pkg::FRAC_W-1:0]   frac_q;
  logic [29:0]                  prod_d, prod_q;
  logic [gta_pkg::T_W:0]        interp;
  logic [gta_pkg::T_W-1:0]      t;
  gta_pkg::factor_t             fac_d, fac_q;

  always_comb begin
    idx_n  = {1'b0, pos_i.idx} + 1'b1;
    lo_d   = TanhTab[pos_i.idx];
    // last segment ends on 1.0
    hi_d   = (32'(idx_n) < gta_pkg::TANH_ENTRIES) ? TanhTab[idx_n[gta_pkg::IDX_W-1:0]]
                                                  : gta_pkg::T_ONE;
    diff_d = (hi_d > lo_d) ? hi_d - lo_d : '0;
    prod_d = 30'(diff_q) * 30'(frac_q);
    interp = {1'b0, lo9_q} + (gta_pkg::T_W + 1)'((prod_q + 30'd8192) >> 14);
    t      = sat9_q ? gta_pkg::T_ONE : interp[gta_pkg::T_W-1:0];
    fac_d.meta = m9_q;
    fac_d.f    = m9_q.neg ? {1'b0, gta_pkg::T_ONE} - {1'b0, t}
                          : {1'b0, gta_pkg::T_ONE} + {1'b0, t};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m8_q   <= pos_i.meta;
      sat8_q <= pos_i.sat;
      lo8_q  <= lo_d;
      diff_q <= diff_d;
      frac_q <= pos_i.frac;
      m9_q   <= m8_q;
      sat9_q <= sat8_q;
      lo9_q  <= lo8_q;
      prod_q <= prod_d;
      fac_q  <= fac_d;
    end
  end

  assign valid_o  = vld_q[2];
  assign factor_o = fac_q;

  a_factor_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (fac_q.meta.neg ? fac_q.f <= 17'd32768
                                 : (fac_q.f >= 17'd32768 && fac_q.f <= 17'd65536)))
    else $error("tanh factor on wrong side of 1.0");

endmodule

[design/gta_output.sv]
// Final product x*(1 + tanh), rounding, sign restore and saturation.
module gta_output (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  gta_pkg::factor_t         factor_i,
  output logic                     valid_o,
  output logic [gta_pkg::X_W-1:0]  sample_o,
  output logic                     last_o
);

  logic [1:0] vld_q;

  logic                        neg11_q, last11_q, neg_q, last_q;
  logic [gta_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic [gta_pkg::AX_W-1:0]    ym;
  logic [gta_pkg::X_W-1:0]     res_d, res_q;

  always_comb begin
    prod_d = gta_pkg::PROD_W'(factor_i.meta.ax) * gta_pkg::PROD_W'(factor_i.f);
    ym     = gta_pkg::AX_W'((prod_q + gta_pkg::PROD_W'(32768)) >> 16);
    if (neg11_q) begin
      res_d = gta_pkg::X_W'(-ym);
    end else if (ym[gta_pkg::AX_W-1] || ym[gta_pkg::X_W-1]) begin
      res_d = 16'h7FFF;
    end else begin
      res_d = ym[gta_pkg::X_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg11_q  <= factor_i.meta.neg;
      last11_q <= factor_i.meta.last;
      prod_q   <= prod_d;
      neg_q    <= neg11_q;
      last_q   <= last11_q;
      res_q    <= res_d;
    end
  end

  assign valid_o  = vld_q[1];
  assign sample_o = res_q;
  assign last_o   = last_q;

  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !neg_q |-> !res_q[gta_pkg::X_W-1])
    else $error("negative result for non-negative input");

  a_neg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && neg_q |-> (res_q[gta_pkg::X_W-1] || res_q == '0))
    else $error("positive result for negative input");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !en_i |=> vld_q[1] && $stable(res_q) && $stable(last_q))
    else $error("result changed while stalled");

endmodule

[tb/sv/gelu_tanh_activation_test.sv]
// Self-checking stream testbench for the tanh-form GELU activation block.
module gelu_tanh_activation_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              RANDOM_ITEMS   = 950;
  localparam longint unsigned Q31_ONE        = 64'd2147483648;
  localparam longint unsigned U_SAT          = 64'd16384;

  typedef struct packed {
    logic [gta_pkg::X_W-1:0] sample;
    logic                    last;
  } gelu_beat_t;

  class gelu_scoreboard;
    logic [gta_pkg::T_W-1:0] tanh_rom [gta_pkg::TANH_ENTRIES];
    gelu_beat_t              pending_q [$];
    int unsigned             mismatches;
    int unsigned             inputs_seen;
    int unsigned             results_seen;
    int unsigned             lasts_seen;
    int unsigned             sat_seen;

    // tanh(4i/N) in Q1.15 from e^(-2t) = (e^(-i/N))^8, all in Q31
    function new();
      longint unsigned r;
      longint unsigned term;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned n;
      longint          sum;
      n = gta_pkg::TANH_ENTRIES;
      for (int i = 0; i < gta_pkg::TANH_ENTRIES; i++) begin
        r    = (64'(i) << 31) / n;
        term = Q31_ONE;
        sum  = longint'(Q31_ONE);
        for (int k = 1; k <= 24; k++) begin
          term = ((term * r) >> 31) / 64'(k);
          if ((k % 2) == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        e = longint'(sum);
        repeat (3) e = (e * e + (64'd1 << 30)) >> 31;
        if (e > Q31_ONE) begin
          e = Q31_ONE;
        end
        num         = (Q31_ONE - e) << 16;
        den         = Q31_ONE + e;
        tanh_rom[i] = gta_pkg::T_W'((num + den) / (2 * den));
      end
      mismatches   = 0;
      inputs_seen  = 0;
      results_seen = 0;
      lasts_seen   = 0;
      sat_seen     = 0;
    endfunction

    // |u| in Q4.12 for magnitude ax of x, rounded to nearest
    function longint unsigned u_mag(longint unsigned ax);
      longint unsigned sm;
      longint unsigned hi;
      longint unsigned lo;
      sm = (ax << 40) + 64'(gta_pkg::GELU_C) * (ax * ax * ax);
      hi = sm >> 32;
      lo = sm & 64'hFFFF_FFFF;
      return (hi * 64'(gta_pkg::GELU_K)
              + ((lo * 64'(gta_pkg::GELU_K) + (64'd1 << 55)) >> 32)) >> 24;
    endfunction

    function logic [gta_pkg::X_W-1:0] gelu_q412(logic [gta_pkg::X_W-1:0] x);
      logic            neg;
      longint unsigned ax;
      longint unsigned um;
      longint unsigned p;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned t;
      longint unsigned f;
      longint unsigned ym;
      longint          y;
      neg = x[gta_pkg::X_W-1];
      ax  = neg ? 64'd65536 - 64'(x) : 64'(x);
      um  = u_mag(ax);
      t   = 64'd32768;
      if (um < U_SAT) begin
        p    = um * gta_pkg::TANH_ENTRIES;
        idx  = p >> 14;
        frac = p & 64'd16383;
        if (idx < gta_pkg::TANH_ENTRIES) begin
          lo = tanh_rom[idx];
          // last segment interpolates toward 1.0
          hi = (idx + 1 < gta_pkg::TANH_ENTRIES) ? 64'(tanh_rom[idx + 1]) : 64'd32768;
          if (hi < lo) begin
            hi = lo;
          end
          t = lo + (((hi - lo) * frac + 64'd8192) >> 14);
        end
      end
      f  = neg ? 64'd32768 - t : 64'd32768 + t;
      ym = (ax * f + 64'd32768) >> 16;
      y  = neg ? -longint'(ym) : longint'(ym);
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      return y[gta_pkg::X_W-1:0];
    endfunction

    function void note_input(logic [gta_pkg::X_W-1:0] x, logic last);
      gelu_beat_t      exp_beat;
      longint unsigned ax;
      ax              = x[gta_pkg::X_W-1] ? 64'd65536 - 64'(x) : 64'(x);
      exp_beat.sample = gelu_q412(x);
      exp_beat.last   = last;
      pending_q.push_back(exp_beat);
      inputs_seen++;
      if (last) begin
        lasts_seen++;
      end
      if (u_mag(ax) >= U_SAT) begin
        sat_seen++;
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [gta_pkg::X_W-1:0] y, logic last);
      gelu_beat_t exp_beat;
      results_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h last %b", y, last));
      end else begin
        exp_beat = pending_q.pop_front();
        if (y !== exp_beat.sample) begin
          report($sformatf("result %0d sample %h, expected %h",
                           results_seen, y, exp_beat.sample));
        end
        if (last !== exp_beat.last) begin
          report($sformatf("result %0d tlast %b, expected %b",
                           results_seen, last, exp_beat.last));
        end
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [gta_pkg::X_W-1:0] s_axis_tdata_i;   // [15:0] sample_in
  logic                    s_axis_tlast_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [gta_pkg::X_W-1:0] m_axis_tdata_o;   // [15:0] sample_out
  logic                    m_axis_tlast_o;

  gelu_scoreboard sb;
  gelu_beat_t     stim_q [$];
  int unsigned    idle_cycles;
  int unsigned    rx_cycle;

  gelu_tanh_activation u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Send queued samples in bursts of random length with random gaps.
  task automatic send_samples();
    gelu_beat_t  beat;
    int unsigned burst;
    int unsigned gap;
    while (stim_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && stim_q.size() != 0; b++) begin
        beat            = stim_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= beat.sample;
        s_axis_tlast_i  <= beat.last;
        do @(posedge clk_i); while (!s_axis_tready_o);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= gta_pkg::X_W'($urandom);
        s_axis_tlast_i  <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  function automatic void queue_sample(logic [gta_pkg::X_W-1:0] x, logic last);
    gelu_beat_t beat;
    beat.sample = x;
    beat.last   = last;
    stim_q.push_back(beat);
  endfunction

  // Receiver stall pattern: always ready, random, periodic, then long stretches.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0:    m_axis_tready_i <= 1'b1;
      2'd1:    m_axis_tready_i <= ($urandom_range(0, 9) < 7);
      2'd2:    m_axis_tready_i <= ((rx_cycle % 3) != 0);
      default: m_axis_tready_i <= ($urandom_range(0, 15) == 0) ? ~m_axis_tready_i
                                                               : m_axis_tready_i;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_input(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned             sat_edge;
    int unsigned             mag;
    int unsigned             kind;
    logic [14:0]             r15;
    logic [gta_pkg::X_W-1:0] x;
    logic                    last;

    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    idle_cycles     = 0;
    rx_cycle        = 0;

    // smallest |x| whose inner value reaches tanh saturation
    sat_edge = 32767;
    for (int v = 0; v < 32768; v++) begin
      if (sb.u_mag(64'(v)) >= U_SAT) begin
        sat_edge = v;
        break;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, smallest steps, range ends, unit points, saturation edge, +-4.0 and alternating bit patterns
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h0001, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'h0002, 1'b0);
    queue_sample(16'hFFFE, 1'b0);
    queue_sample(16'h7FFF, 1'b1);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h8001, 1'b1);
    queue_sample(16'h1000, 1'b0);
    queue_sample(16'hF000, 1'b0);
    queue_sample(16'h2000, 1'b0);
    queue_sample(16'hE000, 1'b1);
    queue_sample(16'(sat_edge - 1), 1'b0);
    queue_sample(16'(sat_edge), 1'b0);
    queue_sample(-16'(sat_edge - 1), 1'b0);
    queue_sample(-16'(sat_edge), 1'b1);
    queue_sample(16'h4000, 1'b0);
    queue_sample(16'hC000, 1'b0);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'hAAAA, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: x = gta_pkg::X_W'($urandom);
        4, 5, 6: begin
          // |x| up to 4, which covers the interpolated tanh region
          r15 = 15'($urandom);
          x   = {r15[14], r15};
        end
        7: x = 16'($urandom_range(0, 2047)) - 16'd1024;
        8: begin
          mag = sat_edge + $urandom_range(0, 128) - 64;
          x   = $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
        end
        default: x = $urandom_range(0, 1) ? 16'h7FF0 + 16'($urandom_range(0, 15))
                                          : 16'h8000 + 16'($urandom_range(0, 15));
      endcase
      last = ($urandom_range(0, 7) == 0);
      queue_sample(x, last);
    end

    send_samples();

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d samples (%0d tlast, %0d past the tanh saturation edge)",
             sb.inputs_seen, sb.lasts_seen, sb.sat_seen);
    $display("Compared %0d results, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/gta_pkg.sv
design/gta_cubic.sv
design/gta_scale.sv
design/gta_tanh.sv
design/gta_output.sv
design/gelu_tanh_activation.sv
tb/sv/gelu_tanh_activation_test.sv
